// File: hw/rtl/drnm_pkg.sv
// Types, codes and constants shared by the direct ring network manager files.
package drnm_pkg;

    // NM states
    typedef enum logic [3:0] {
        ST_OFF       = 4'd0,
        ST_INIT      = 4'd1,
        ST_INITRESET = 4'd2,
        ST_NORMAL    = 4'd3,
        ST_NPREP     = 4'd4,
        ST_TWBSN     = 4'd5,
        ST_BUSSLEEP  = 4'd6,
        ST_LIMP      = 4'd7,
        ST_LPREP     = 4'd8,
        ST_TWBSL     = 4'd9
    } t_mode;

    // Event codes
    typedef enum logic [3:0] {
        OP_TICK   = 4'd0,
        OP_RX     = 4'd1,
        OP_START  = 4'd2,
        OP_STOP   = 4'd3,
        OP_SLEEP  = 4'd4,
        OP_AWAKE  = 4'd5,
        OP_TALK   = 4'd6,
        OP_SILENT = 4'd7,
        OP_WAKEUP = 4'd8,
        OP_BUSERR = 4'd9
    } t_op;

    // Configuration register indexes
    localparam logic [2:0] CFG_NODE_ID   = 3'd0;
    localparam logic [2:0] CFG_BASE_ID   = 3'd1;
    localparam logic [2:0] CFG_TX_THRESH = 3'd2;
    localparam logic [2:0] CFG_RX_THRESH = 3'd3;
    localparam logic [2:0] CFG_TYP       = 3'd4;
    localparam logic [2:0] CFG_MAX       = 3'd5;
    localparam logic [2:0] CFG_ERROR     = 3'd6;
    localparam logic [2:0] CFG_WBS       = 3'd7;

    // PDU opcode byte bits
    localparam logic [7:0] F_ALIVE = 8'h01;
    localparam logic [7:0] F_RING  = 8'h02;
    localparam logic [7:0] F_LIMP  = 8'h04;
    localparam logic [7:0] F_SI    = 8'h10;
    localparam logic [7:0] F_SA    = 8'h20;

    // Marker and status flag bits
    localparam logic [2:0] M_STABLE   = 3'b001;
    localparam logic [2:0] M_LIMP     = 3'b010;
    localparam logic [2:0] M_FIRST    = 3'b100;
    localparam logic [2:0] S_ACTIVE   = 3'b001;
    localparam logic [2:0] S_BUSSLEEP = 3'b010;
    localparam logic [2:0] S_CSTABLE  = 3'b100;

    // Alarm numbers
    localparam logic [1:0] A_TYP = 2'd0;
    localparam logic [1:0] A_MAX = 2'd1;
    localparam logic [1:0] A_ERR = 2'd2;
    localparam logic [1:0] A_WBS = 2'd3;

    // Configuration values
    typedef struct packed {
        logic [7:0]       node_id;
        logic [10:0]      base_id;
        logic [7:0]       tx_thresh;
        logic [7:0]       rx_thresh;
        logic [3:0][15:0] dur;
    } t_cfg;

    // Persistent manager state
    typedef struct packed {
        t_mode            mode;
        logic [7:0]       own_dest;
        logic [7:0]       own_flags;
        logic [7:0]       rx_cnt;
        logic [7:0]       tx_cnt;
        logic [2:0]       marker;
        logic [2:0]       status;
        logic [3:0]       run;
        logic [3:0][15:0] cnt;
    } t_nm_state;

    // State plus the frames sent while one event is handled
    typedef struct packed {
        t_nm_state       st;
        logic [1:0]      fn;
        logic [1:0][7:0] fdest;
        logic [1:0][7:0] fflg;
    } t_work;

endpackage

// File: hw/rtl/drnm_core.sv
// Combinational event handler: next manager state and the frames of one event.
module drnm_core (
    input  drnm_pkg::t_cfg  i_cfg,
    input  drnm_pkg::t_nm_state i_state,
    input  logic [3:0]      i_opcode,
    input  logic [7:0]      i_rx_source,
    input  logic [7:0]      i_rx_dest,
    input  logic [7:0]      i_rx_flags,
    input  logic            i_acc_active,
    output drnm_pkg::t_work o_work
);
    import drnm_pkg::*;

    function automatic logic [7:0] f_sat(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic t_work f_set(input t_work w, input logic [1:0] a);
        t_work r;
        r = w;
        r.st.run[a] = 1'b1;
        r.st.cnt[a] = '0;
        return r;
    endfunction

    function automatic t_work f_cancel(input t_work w, input logic [1:0] a);
        t_work r;
        r = w;
        r.st.run[a] = 1'b0;
        return r;
    endfunction

    // A running alarm counts one tick, saturating.
    function automatic t_work f_adv(input t_work w, input logic [1:0] a);
        t_work r;
        r = w;
        if (r.st.run[a] && r.st.cnt[a] != 16'hFFFF) begin
            r.st.cnt[a] = r.st.cnt[a] + 16'd1;
        end
        return r;
    endfunction

    function automatic logic f_to(input t_work w, input t_cfg c, input logic [1:0] a);
        return w.st.run[a] && (w.st.cnt[a] >= c.dur[a]);
    endfunction

    // Records the own PDU as a sent frame.
    function automatic t_work f_push(input t_work w);
        t_work r;
        r = w;
        if (r.fn != 2'd2) begin
            r.fdest[r.fn[0]] = r.st.own_dest;
            r.fflg[r.fn[0]]  = r.st.own_flags;
            r.fn = r.fn + 2'd1;
        end
        return r;
    endfunction

    // Reset of the ring; its own alive frame is confirmed in the reset state.
    function automatic t_work f_ir6(input t_work w, input t_cfg c);
        t_work r;
        r = w;
        r.st.mode      = ST_INITRESET;
        r.st.rx_cnt    = f_sat(r.st.rx_cnt);
        r.st.own_dest  = c.node_id;
        r.st.own_flags = '0;
        r.st.marker    = '0;
        r.st.run       = '0;
        if ((r.st.status & S_ACTIVE) != '0) begin
            r.st.tx_cnt    = f_sat(r.st.tx_cnt);
            r.st.own_flags = F_ALIVE;
            r = f_push(r);
            r.st.tx_cnt = '0;
        end
        if (r.st.tx_cnt <= c.tx_thresh && r.st.rx_cnt <= c.rx_thresh) begin
            r = f_set(r, A_TYP);
            r.st.mode = ST_NORMAL;
        end else begin
            r = f_set(r, A_ERR);
            r.st.mode = ST_LIMP;
        end
        return r;
    endfunction

    function automatic t_work f_ir5(input t_work w, input t_cfg c);
        t_work r;
        r = f_cancel(w, A_ERR);
        r.st.rx_cnt = '0;
        r.st.tx_cnt = '0;
        return f_ir6(r, c);
    endfunction

    function automatic t_work f_init3(input t_work w, input t_cfg c);
        t_work r;
        r = w;
        r.st.rx_cnt = '0;
        r.st.tx_cnt = '0;
        return f_ir6(r, c);
    endfunction

    // Send with immediate transmit confirmation.
    function automatic t_work f_send(input t_work w, input t_cfg c);
        t_work r;
        r = f_push(w);
        r.st.tx_cnt = '0;
        case (r.st.mode)
            ST_NORMAL: begin
                if ((r.st.own_flags & F_RING) != '0) begin
                    r = f_cancel(r, A_TYP);
                    r = f_set(r, A_MAX);
                    if ((r.st.own_flags & F_SI) != '0 &&
                        (r.st.status & S_BUSSLEEP) != '0) begin
                        r.st.own_flags = r.st.own_flags | F_SA;
                        r.st.mode = ST_NPREP;
                    end
                end
            end
            ST_NPREP: begin
                if ((r.st.own_flags & F_RING) != '0) begin
                    r = f_set(r, A_WBS);
                    r.st.mode = ST_TWBSN;
                end
            end
            ST_LIMP: begin
                if ((r.st.own_flags & F_LIMP) != '0) begin
                    r.st.marker = r.st.marker | M_LIMP;
                    if ((r.st.marker & M_FIRST) != '0) r = f_ir5(r, c);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] f_succ(input logic [7:0] s, input logic [7:0] rr,
                                          input logic [7:0] l);
        logic [7:0] res;
        if (l == rr) res = s;
        else if (l < rr) res = (s < l || s >= rr) ? s : l;
        else res = (s < l && s >= rr) ? s : l;
        return res;
    endfunction

    function automatic logic f_skip(input logic [7:0] s, input logic [7:0] rr,
                                    input logic [7:0] d);
        logic res;
        if (d < rr) res = !(s < d) && (s < rr);
        else if (s < d) res = s < rr;
        else res = 1'b1;
        return res;
    endfunction

    function automatic t_work f_max_check(input t_work w, input t_cfg c);
        t_work r;
        r = f_adv(w, A_MAX);
        if (f_to(r, c, A_MAX)) begin
            r = f_cancel(r, A_MAX);
            r = f_ir6(r, c);
        end
        return r;
    endfunction

    function automatic t_work f_tick(input t_work w, input t_cfg c);
        t_work r;
        r = w;
        case (r.st.mode)
            ST_NORMAL: begin
                r = f_adv(r, A_TYP);
                if (f_to(r, c, A_TYP)) begin
                    r = f_cancel(r, A_TYP);
                    r = f_set(r, A_MAX);
                    if ((r.st.status & S_ACTIVE) != '0) begin
                        r.st.own_flags = F_RING;
                        if ((r.st.status & S_BUSSLEEP) != '0) begin
                            r.st.own_flags = r.st.own_flags | F_SI;
                        end
                        r.st.tx_cnt = f_sat(r.st.tx_cnt);
                        r = f_send(r, c);
                    end
                    if (r.st.tx_cnt > c.tx_thresh) begin
                        r.st.mode = ST_LIMP;
                        r = f_set(r, A_ERR);
                    end else if ((r.st.marker & M_STABLE) != '0) begin
                        r.st.status = r.st.status | S_CSTABLE;
                    end else begin
                        r.st.marker = r.st.marker | M_STABLE;
                    end
                end
                r = f_max_check(r, c);
            end
            ST_LIMP: begin
                r = f_adv(r, A_ERR);
                if (f_to(r, c, A_ERR)) begin
                    r = f_cancel(r, A_ERR);
                    r.st.own_flags = F_LIMP;
                    if ((r.st.status & S_BUSSLEEP) != '0) begin
                        r = f_set(r, A_MAX);
                        r.st.own_flags = r.st.own_flags | F_SI;
                        r.st.mode = ST_LPREP;
                    end else begin
                        r = f_set(r, A_ERR);
                    end
                    if ((r.st.status & S_ACTIVE) != '0) r = f_send(r, c);
                end
            end
            ST_NPREP: begin
                r = f_adv(r, A_TYP);
                if (f_to(r, c, A_TYP)) begin
                    r = f_cancel(r, A_TYP);
                    if ((r.st.status & S_ACTIVE) != '0) begin
                        r.st.own_flags = F_RING | F_SI | F_SA;
                        r = f_send(r, c);
                    end
                end
                r = f_max_check(r, c);
            end
            ST_TWBSN, ST_TWBSL: begin
                r = f_adv(r, A_WBS);
                if (f_to(r, c, A_WBS)) begin
                    r = f_cancel(r, A_WBS);
                    r.st.mode = ST_BUSSLEEP;
                end
            end
            ST_LPREP: begin
                r = f_adv(r, A_MAX);
                if (f_to(r, c, A_MAX)) begin
                    r = f_cancel(r, A_MAX);
                    r = f_set(r, A_WBS);
                    r.st.mode = ST_TWBSL;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Ring handling shared by normal and prepare-sleep states.
    function automatic t_work f_normal_std(input t_work w, input t_cfg c,
                                           input logic [7:0] src, input logic [7:0] dst,
                                           input logic [7:0] fl);
        t_work r;
        r = w;
        r.st.rx_cnt = '0;
        if ((fl & F_LIMP) == '0) begin
            r.st.own_dest = f_succ(src, c.node_id, r.st.own_dest);
            if ((fl & F_RING) != '0) begin
                r = f_cancel(r, A_TYP);
                r = f_cancel(r, A_MAX);
                if (dst == c.node_id || dst == src) begin
                    r = f_set(r, A_TYP);
                end else begin
                    r = f_set(r, A_MAX);
                    if (f_skip(src, c.node_id, dst) && (r.st.status & S_ACTIVE) != '0) begin
                        r.st.own_flags = F_ALIVE;
                        r.st.own_dest  = c.node_id;
                        if ((r.st.status & S_BUSSLEEP) != '0) begin
                            r.st.own_flags = r.st.own_flags | F_SI;
                        end
                        r = f_send(r, c);
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic t_work f_twbs_limp(input t_work w);
        t_work r;
        r = f_set(w, A_WBS);
        r.st.mode = ST_TWBSL;
        return r;
    endfunction

    function automatic t_work f_rx(input t_work w, input t_cfg c, input logic [7:0] src,
                                   input logic [7:0] dst, input logic [7:0] fl,
                                   input logic acc);
        t_work r;
        logic  sa, si, limp, act, bs;
        r    = w;
        sa   = (fl & F_SA) != '0;
        si   = (fl & F_SI) != '0;
        limp = (w.st.marker & M_LIMP) != '0;
        act  = (w.st.status & S_ACTIVE) != '0;
        bs   = (w.st.status & S_BUSSLEEP) != '0;
        case (r.st.mode)
            ST_NORMAL, ST_NPREP: begin
                r = f_normal_std(r, c, src, dst, fl);
                if (sa && (r.st.status & S_BUSSLEEP) != '0) begin
                    r = f_set(r, A_WBS);
                    r.st.mode = ST_TWBSN;
                end
                if (r.st.mode == ST_NPREP && !si) r.st.mode = ST_NORMAL;
            end
            ST_TWBSN: begin
                if (!si) begin
                    r = f_cancel(r, A_WBS);
                    r = f_ir6(r, c);
                end
            end
            ST_LIMP: begin
                if (act) begin
                    if (limp) begin
                        if (sa && !acc) begin
                            r = f_twbs_limp(r);
                            r = f_cancel(r, A_ERR);
                        end else begin
                            r = f_ir5(r, c);
                        end
                    end else if (r.st.rx_cnt > c.rx_thresh) begin
                        r.st.marker = r.st.marker | M_FIRST;
                    end else if (sa) begin
                        r = f_twbs_limp(r);
                    end else begin
                        r = f_ir5(r, c);
                    end
                end else begin
                    if (limp) begin
                        if (bs && sa) r = f_twbs_limp(r);
                        else r = f_ir5(r, c);
                    end else if (sa) begin
                        r = f_twbs_limp(r);
                    end else begin
                        r = f_ir5(r, c);
                    end
                end
            end
            ST_LPREP: begin
                if (!sa) begin
                    r = f_init3(r, c);
                end else begin
                    r = f_set(r, A_WBS);
                    r = f_cancel(r, A_ERR);
                    r.st.mode = ST_TWBSL;
                end
            end
            ST_TWBSL: begin
                if (!si) begin
                    r = f_cancel(r, A_WBS);
                    r.st.mode = ST_LIMP;
                    r = f_set(r, A_ERR);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_work f_awake(input t_work w, input t_cfg c);
        t_work r;
        r = w;
        r.st.status = r.st.status & ~S_BUSSLEEP;
        case (r.st.mode)
            ST_NPREP: r.st.mode = ST_NORMAL;
            ST_TWBSN: begin
                r = f_cancel(r, A_WBS);
                r = f_ir6(r, c);
            end
            ST_BUSSLEEP: r = f_init3(r, c);
            ST_LPREP: begin
                r.st.mode = ST_LIMP;
                r = f_set(r, A_ERR);
            end
            ST_TWBSL: begin
                r = f_cancel(r, A_WBS);
                r.st.mode = ST_LIMP;
                r = f_set(r, A_ERR);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Dispatch on the event code
    always_comb begin
        t_work w;
        w.st    = i_state;
        w.fn    = '0;
        w.fdest = '0;
        w.fflg  = '0;
        case (t_op'(i_opcode))
            OP_TICK: w = f_tick(w, i_cfg);
            OP_RX:   w = f_rx(w, i_cfg, i_rx_source, i_rx_dest, i_rx_flags, i_acc_active);
            OP_START: begin
                w.st.mode = ST_INIT;
                w = f_init3(w, i_cfg);
            end
            OP_STOP: w.st.mode = ST_OFF;
            OP_SLEEP: begin
                w.st.status = w.st.status | S_BUSSLEEP;
                if (w.st.mode == ST_NORMAL && (w.st.status & S_ACTIVE) == '0) begin
                    w.st.mode = ST_NPREP;
                end
            end
            OP_AWAKE:  w = f_awake(w, i_cfg);
            OP_TALK:   w.st.status = w.st.status | S_ACTIVE;
            OP_SILENT: w.st.status = w.st.status & ~S_ACTIVE;
            OP_WAKEUP: begin
                if (w.st.mode == ST_BUSSLEEP) w = f_init3(w, i_cfg);
            end
            OP_BUSERR: begin
                w = f_set(w, A_ERR);
                w.st.mode = ST_LIMP;
            end
            default: ;
        endcase
        o_work = w;
    end

endmodule

// File: hw/rtl/direct_ring_network_manager.sv
// Top level of the direct ring network manager: registers, config port and result output.
// Usage:
//   Events enter on the s_axis channel: tuser carries the event code, tdata the
//   received PDU fields and the accessory status. Results leave on the m_axis
//   channel, one or two per event; tlast marks the final result of an event and
//   tuser says whether the result carries a transmitted frame.
//   Registers are to be written on the cfg channel (index, data) only while no event
//   is in flight; the block itself does not enforce this. The channel is always ready.
// Data path:
//   An accepted event is held in an input register, handled by the combinational
//   event logic and written to the result register, from which the first result
//   is shown. An event that sends one frame or none gives one result; an event
//   that sends two frames occupies the result register for both results, shown
//   one after the other.
// Reset and stalls:
//   Reset puts the manager in the init state with all alarms stopped, counters
//   and flags cleared and the registers at their default values. When the
//   receiver stalls, the result register holds, one more event waits in the
//   input register, and only then does s_axis tready fall.
module direct_ring_network_manager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] rx_source, [15:8] rx_dest, [23:16] rx_flags, [24] acc_active
    input  logic [31:0] i_s_axis_tdata,
    // [3:0] opcode
    input  logic [3:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [10:0] tx_can_id, [18:11] tx_dest, [26:19] tx_flags, [30:27] nm_state,
    // [31] sleep_phase, [32] config_stable
    output logic [39:0] o_m_axis_tdata,
    // [0] tx_valid
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import drnm_pkg::*;

    t_cfg       r_cfg;
    t_nm_state  r_state;
    t_work      w_work;

    logic       r_in_valid;
    logic [3:0] r_opcode;
    logic [7:0] r_src, r_dst, r_flg;
    logic       r_acc;

    logic            r_out_valid;
    logic            r_sel;
    logic [1:0]      r_fn;
    logic [1:0][7:0] r_fdest, r_fflg;
    t_mode           r_mode;
    logic            r_cst;

    logic w_consume, w_out_free, w_last, w_txv, w_sp;
    logic [1:0] w_num;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_id   <= 8'h17;
            r_cfg.base_id   <= 11'h100;
            r_cfg.tx_thresh <= 8'd4;
            r_cfg.rx_thresh <= 8'd8;
            r_cfg.dur[A_TYP] <= 16'd100;
            r_cfg.dur[A_MAX] <= 16'd260;
            r_cfg.dur[A_ERR] <= 16'd1000;
            r_cfg.dur[A_WBS] <= 16'd1500;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NODE_ID:   r_cfg.node_id   <= i_cfg_data[7:0];
                CFG_BASE_ID:   r_cfg.base_id   <= i_cfg_data[10:0];
                CFG_TX_THRESH: r_cfg.tx_thresh <= i_cfg_data[7:0];
                CFG_RX_THRESH: r_cfg.rx_thresh <= i_cfg_data[7:0];
                CFG_TYP:       r_cfg.dur[A_TYP] <= i_cfg_data;
                CFG_MAX:       r_cfg.dur[A_MAX] <= i_cfg_data;
                CFG_ERROR:     r_cfg.dur[A_ERR] <= i_cfg_data;
                CFG_WBS:       r_cfg.dur[A_WBS] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake control
    assign w_num      = (r_fn == 2'd0) ? 2'd1 : r_fn;
    assign w_last     = ({1'b0, r_sel} + 2'd1) == w_num;
    assign w_out_free = !r_out_valid || (i_m_axis_tready && w_last);
    assign w_consume  = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_consume;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_opcode <= i_s_axis_tuser;
            r_src    <= i_s_axis_tdata[7:0];
            r_dst    <= i_s_axis_tdata[15:8];
            r_flg    <= i_s_axis_tdata[23:16];
            r_acc    <= i_s_axis_tdata[24];
        end
    end

    drnm_core u_core (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_opcode     (r_opcode),
        .i_rx_source  (r_src),
        .i_rx_dest    (r_dst),
        .i_rx_flags   (r_flg),
        .i_acc_active (r_acc),
        .o_work       (w_work)
    );

    // Manager state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode      <= ST_INIT;
            r_state.own_dest  <= '0;
            r_state.own_flags <= '0;
            r_state.rx_cnt    <= '0;
            r_state.tx_cnt    <= '0;
            r_state.marker    <= '0;
            r_state.status    <= '0;
            r_state.run       <= '0;
            r_state.cnt       <= '0;
        end else if (w_consume) begin
            r_state <= w_work.st;
        end
    end

    // Result register, shown one result at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sel       <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_consume;
            r_sel       <= 1'b0;
        end else if (i_m_axis_tready) begin
            r_sel <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume) begin
            r_fn    <= w_work.fn;
            r_fdest <= w_work.fdest;
            r_fflg  <= w_work.fflg;
            r_mode  <= w_work.st.mode;
            r_cst   <= (w_work.st.status & S_CSTABLE) != '0;
        end
    end

    // Output fields
    assign w_txv = {1'b0, r_sel} < r_fn;
    assign w_sp  = (r_mode == ST_TWBSN) || (r_mode == ST_BUSSLEEP) || (r_mode == ST_TWBSL);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = w_txv;
    assign o_m_axis_tlast  = w_last;
    assign o_m_axis_tdata  = {7'd0, r_cst, w_sp, r_mode,
                              w_txv ? r_fflg[r_sel] : 8'd0,
                              w_txv ? r_fdest[r_sel] : 8'd0,
                              w_txv ? (r_cfg.base_id | {3'd0, r_cfg.node_id}) : 11'd0};

endmodule
